@@ rtl/core/lbs_pkg.sv @@
`timescale 1ns / 1ps

package lbs_pkg;

  // Store geometry
  localparam int DEPTH     = 8;
  localparam int LINE_LEN  = 64;
  localparam int ADDR_W    = $clog2(DEPTH * LINE_LEN);
  localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int LEN_W     = $clog2(LINE_LEN);
  localparam int POP_LEN_W = 7;

  // Request action codes
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_EOL  = 2'd1;
  localparam logic [1:0] ACT_POP  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_DATA  = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_LONG  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_END   = 3'd5;

  // Line memory access
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

endpackage

@@ rtl/core/lbs_line_mem.sv @@
`timescale 1ns / 1ps

module lbs_line_mem (
  input  logic              clk,
  input  lbs_pkg::mem_req_t req,
  output logic [7:0]        rdata
);
  import lbs_pkg::*;

  logic [7:0] mem [DEPTH*LINE_LEN];

  // Single port: write or registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

@@ rtl/core/lbs_ctrl.sv @@
`timescale 1ns / 1ps

module lbs_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic [7:0]                    in_ch,
  input  logic [lbs_pkg::POP_LEN_W-1:0] in_pop_len,
  output lbs_pkg::mem_req_t             mem_req,
  input  logic [7:0]                    mem_rdata,
  output logic                          out_strobe,
  output logic [7:0]                    out_byte,
  output logic [2:0]                    out_status,
  output logic                          out_last
);
  import lbs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_END  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]  plen_r, plen_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]  n_r, n_nxt;
  logic              ostb_r, ostb_nxt;
  logic [2:0]        ost_r, ost_nxt;
  logic              olast_r, olast_nxt;
  logic              odata_r, odata_nxt;

  // Committed line lengths, one register per slot
  logic [LEN_W-1:0]  lens_r [DEPTH];
  logic              lens_we;

  logic                 is_eol;
  logic                 full;
  logic [SLOT_W-1:0]    top_slot;
  logic [POP_LEN_W-1:0] pl_m1;
  logic [POP_LEN_W-1:0] top_len;
  logic [POP_LEN_W-1:0] n_calc;

  assign busy     = (state_r != S_IDLE);
  assign is_eol   = (in_action == ACT_EOL) || ((in_action == ACT_PUSH) && (in_ch == 8'd0));
  assign full     = (count_r == CNT_W'(DEPTH));
  assign top_slot = SLOT_W'(count_r - 1'b1);

  // Pop byte count: min(max(pop_len,1)-1, line length)
  assign pl_m1   = (in_pop_len == '0) ? '0 : in_pop_len - 1'b1;
  assign top_len = POP_LEN_W'(lens_r[top_slot]);
  assign n_calc  = (pl_m1 < top_len) ? pl_m1 : top_len;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    plen_nxt  = plen_r;
    ovf_nxt   = ovf_r;
    base_nxt  = base_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    ostb_nxt  = 1'b0;
    ost_nxt   = ST_DATA;
    olast_nxt = 1'b0;
    odata_nxt = 1'b0;
    lens_we   = 1'b0;
    mem_req   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority if ((in_action == ACT_PUSH) && (in_ch != 8'd0)) begin
            // Append byte to pending line
            if (!ovf_r) begin
              if (plen_r == LEN_W'(LINE_LEN - 1)) begin
                ovf_nxt = 1'b1;
              end else begin
                mem_req.wr_en = !full;
                mem_req.addr  = ADDR_W'(count_r) * ADDR_W'(LINE_LEN) + ADDR_W'(plen_r);
                mem_req.wdata = in_ch;
                plen_nxt      = plen_r + 1'b1;
              end
            end
          end else if (is_eol) begin
            // Commit or reject the pending line
            ostb_nxt  = 1'b1;
            olast_nxt = 1'b1;
            plen_nxt  = '0;
            ovf_nxt   = 1'b0;
            if (full) begin
              ost_nxt = ST_FULL;
            end else if (ovf_r) begin
              ost_nxt = ST_LONG;
            end else begin
              ost_nxt   = ST_DONE;
              lens_we   = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end else if (in_action == ACT_POP) begin
            plen_nxt = '0;
            ovf_nxt  = 1'b0;
            if (count_r == '0) begin
              ostb_nxt  = 1'b1;
              olast_nxt = 1'b1;
              ost_nxt   = ST_EMPTY;
            end else begin
              count_nxt = count_r - 1'b1;
              base_nxt  = ADDR_W'(top_slot) * ADDR_W'(LINE_LEN);
              idx_nxt   = '0;
              n_nxt     = n_calc[LEN_W-1:0];
              if (n_calc == '0) begin
                ostb_nxt  = 1'b1;
                olast_nxt = 1'b1;
                ost_nxt   = ST_END;
              end else begin
                state_nxt = S_POP;
              end
            end
          end else begin
            // Unused action: no effect
            state_nxt = S_IDLE;
          end
        end
      end
      S_POP: begin
        // One byte read per cycle; data shows the cycle after
        mem_req.rd_en = 1'b1;
        mem_req.addr  = base_r + ADDR_W'(idx_r);
        ostb_nxt      = 1'b1;
        odata_nxt     = 1'b1;
        idx_nxt       = idx_r + 1'b1;
        if (idx_r == n_r - 1'b1) begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        ostb_nxt  = 1'b1;
        olast_nxt = 1'b1;
        ost_nxt   = ST_END;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      plen_r  <= '0;
      ovf_r   <= 1'b0;
      ostb_r  <= 1'b0;
      ost_r   <= ST_DATA;
      olast_r <= 1'b0;
      odata_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      plen_r  <= plen_nxt;
      ovf_r   <= ovf_nxt;
      ostb_r  <= ostb_nxt;
      ost_r   <= ost_nxt;
      olast_r <= olast_nxt;
      odata_r <= odata_nxt;
    end
  end

  // Pop bookkeeping, no reset needed
  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
  end

  // Length table write on commit
  always_ff @(posedge clk) begin
    if (lens_we) begin
      lens_r[count_r[SLOT_W-1:0]] <= plen_r;
    end
  end

  assign out_strobe = ostb_r;
  assign out_status = ost_r;
  assign out_last   = olast_r;
  assign out_byte   = odata_r ? mem_rdata : 8'd0;

endmodule

@@ rtl/core/bounded_line_stack_unit.sv @@
`timescale 1ns / 1ps
// Channel   Handshake            Fields
// input     start & !busy        in_action, in_ch, in_pop_len
// result    out_strobe (1 cycle) out_byte, out_status, out_last
//
// Push byte, end of line, unused action and a pop that returns no byte do not
// raise busy; the result (if any) shows the cycle after the request.
// A pop of n > 0 bytes keeps busy high through the S_POP and S_END states:
// the line memory has one read port, one byte per cycle, with a registered read.
// Reset (rst_n low, synchronous) empties the stack and the pending line.
// Results cannot be stalled by the receiver.

module bounded_line_stack_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic [7:0]                    in_ch,
  input  logic [lbs_pkg::POP_LEN_W-1:0] in_pop_len,
  output logic                          out_strobe,
  output logic [7:0]                    out_byte,
  output logic [2:0]                    out_status,
  output logic                          out_last
);
  import lbs_pkg::*;

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  lbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_action  (in_action),
    .in_ch      (in_ch),
    .in_pop_len (in_pop_len),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .out_strobe (out_strobe),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

  lbs_line_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

@@ rtl/core/lbs_checker.sv @@
`timescale 1ns / 1ps

module lbs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    in_action,
  input logic [7:0]                    in_ch,
  input logic                          out_strobe,
  input logic [7:0]                    out_byte,
  input logic [2:0]                    out_status,
  input logic                          out_last
);
  import lbs_pkg::*;

  // Only data bytes are non-final
  a_last_iff_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_last == (out_status != ST_DATA)))
    else $error("last flag disagrees with status");

  // Status results carry a zero byte
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_DATA)) |-> (out_byte == 8'd0))
    else $error("status result with nonzero byte");

  // A pop stream has no gaps up to its terminator
  a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> out_strobe)
    else $error("gap inside pop stream");

  // End of line gives one push status the next cycle
  a_eol_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_EOL)) |=>
      (out_strobe && out_last &&
       ((out_status == ST_DONE) || (out_status == ST_FULL) || (out_status == ST_LONG))))
    else $error("missing push status after end of line");

  // A nonzero push byte gives no result
  a_push_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_PUSH) && (in_ch != 8'd0)) |=> !out_strobe)
    else $error("result after push byte");

endmodule

bind bounded_line_stack_unit lbs_checker u_lbs_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import lbs_pkg::*;

  // Action code the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int REQUEST_TARGET = 220;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] status;
    logic       last;
  } line_result_t;

  // Tracks the stack of lines and checks every result against it
  class line_stack_checker;
    logic [7:0]   lines [DEPTH][LINE_LEN];
    int unsigned  line_lens [DEPTH];
    int unsigned  line_total;
    int unsigned  pend_len;
    bit           pend_overflow;
    line_result_t awaited_results [$];
    int unsigned  mismatch_count;

    function new();
      line_total     = 0;
      pend_len       = 0;
      pend_overflow  = 0;
      mismatch_count = 0;
    endfunction

    function void await_result(logic [7:0] data, logic [2:0] status, logic last);
      line_result_t r;
      r.data   = data;
      r.status = status;
      r.last   = last;
      awaited_results.push_back(r);
    endfunction

    function void note_request(logic [1:0] action, logic [7:0] ch,
                               logic [POP_LEN_W-1:0] pop_len);
      int unsigned slot;
      int unsigned keep;
      if (action == ACT_PUSH && ch != 8'd0) begin
        // byte into the pending line; only stored while a slot is free
        if (!pend_overflow) begin
          if (pend_len >= LINE_LEN - 1) begin
            pend_overflow = 1;
          end else begin
            if (line_total < DEPTH) lines[line_total][pend_len] = ch;
            pend_len++;
          end
        end
      end else if (action == ACT_PUSH || action == ACT_EOL) begin
        // full check wins over the length check
        if (line_total >= DEPTH) begin
          await_result(8'd0, ST_FULL, 1'b1);
        end else if (pend_overflow) begin
          await_result(8'd0, ST_LONG, 1'b1);
        end else begin
          line_lens[line_total] = pend_len;
          line_total++;
          await_result(8'd0, ST_DONE, 1'b1);
        end
        pend_len      = 0;
        pend_overflow = 0;
      end else if (action == ACT_POP) begin
        pend_len      = 0;
        pend_overflow = 0;
        if (line_total == 0) begin
          await_result(8'd0, ST_EMPTY, 1'b1);
        end else begin
          slot = line_total - 1;
          keep = (pop_len == 0) ? 0 : pop_len - 1;
          if (keep > line_lens[slot]) keep = line_lens[slot];
          for (int i = 0; i < keep; i++) await_result(lines[slot][i], ST_DATA, 1'b0);
          await_result(8'd0, ST_END, 1'b1);
          line_total = slot;
        end
      end
    endfunction

    function void report(string what, line_result_t want, line_result_t got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s: expected byte %02h status %0d last %0d, %s %02h status %0d last %0d",
                 $realtime, what, want.data, want.status, want.last,
                 "got byte", got.data, got.status, got.last);
    endfunction

    function void check_result(logic [7:0] data, logic [2:0] status, logic last);
      line_result_t want;
      line_result_t got;
      got.data   = data;
      got.status = status;
      got.last   = last;
      if (awaited_results.size() == 0) begin
        want = '0;
        report("result with none awaited", want, got);
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) report("result mismatch", want, got);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_action;
  logic [7:0]           in_ch;
  logic [POP_LEN_W-1:0] in_pop_len;
  logic                 out_strobe;
  logic [7:0]           out_byte;
  logic [2:0]           out_status;
  logic                 out_last;

  line_stack_checker checker_h = new();
  int unsigned       request_count = 0;
  int unsigned       cycle_count = 0;
  bit                gaps_on = 1;

  bounded_line_stack_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_action  (in_action),
    .in_ch      (in_ch),
    .in_pop_len (in_pop_len),
    .out_strobe (out_strobe),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Results: the receiver takes every strobe
  always @(posedge clk) begin
    if (rst_n && out_strobe) checker_h.check_result(out_byte, out_status, out_last);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One request: optional idle gap, then hold until accepted
  task automatic send_request(logic [1:0] action, logic [7:0] ch,
                              logic [POP_LEN_W-1:0] pop_len);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 20) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start      <= 1'b1;
    in_action  <= action;
    in_ch      <= ch;
    in_pop_len <= pop_len;
    @(posedge clk);
    while (busy) @(posedge clk);
    checker_h.note_request(action, ch, pop_len);
    if (action != ACT_UNUSED) request_count++;
    @(negedge clk);
  endtask

  function automatic logic [POP_LEN_W-1:0] random_pop_len();
    if ($urandom_range(0, 1)) return POP_LEN_W'($urandom_range(0, 64));
    return POP_LEN_W'($urandom_range(0, 8));
  endfunction

  // n random nonzero bytes, then end of line or a zero byte
  task automatic send_line(int unsigned n);
    for (int i = 0; i < n; i++)
      send_request(ACT_PUSH, 8'($urandom_range(1, 255)), random_pop_len());
    if ($urandom_range(0, 99) < 70)
      send_request(ACT_EOL, 8'($urandom_range(0, 255)), random_pop_len());
    else
      send_request(ACT_PUSH, 8'd0, random_pop_len());
  endtask

  task automatic send_pop(logic [POP_LEN_W-1:0] pop_len);
    send_request(ACT_POP, 8'($urandom_range(0, 255)), pop_len);
  endtask

  initial begin
    int unsigned pick;
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_action  <= ACT_PUSH;
    in_ch      <= 8'd0;
    in_pop_len <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty pop, field extremes, zero byte, unused code
    send_pop(7'd5);
    send_request(ACT_PUSH, 8'h01, 7'd0);
    send_request(ACT_PUSH, 8'hFF, 7'd64);
    send_request(ACT_PUSH, 8'h80, 7'd0);
    send_request(ACT_PUSH, 8'h7E, 7'd64);
    send_request(ACT_EOL, 8'h00, 7'd0);
    send_pop(7'd64);
    send_request(ACT_PUSH, 8'h00, 7'd0);
    send_pop(7'd0);
    send_request(ACT_UNUSED, 8'hA5, 7'd64);
    // pop while a line is pending discards it
    send_request(ACT_PUSH, 8'h42, 7'd0);
    send_pop(7'd3);
    // pop shorter than the line
    send_request(ACT_PUSH, 8'h33, 7'd0);
    send_request(ACT_PUSH, 8'h44, 7'd0);
    send_request(ACT_EOL, 8'hFF, 7'd0);
    send_pop(7'd2);
    // fill the stack, then end of line on a full stack
    for (int i = 0; i < DEPTH; i++) send_request(ACT_EOL, 8'h00, 7'd0);
    send_request(ACT_PUSH, 8'h11, 7'd0);
    send_request(ACT_EOL, 8'h00, 7'd0);

    // longest line that fits, popped whole; then one byte too many
    send_pop(random_pop_len());
    send_line(LINE_LEN - 1);
    send_pop(7'd64);
    send_line(LINE_LEN);

    // random lines, pops and noise
    while (request_count < REQUEST_TARGET) begin
      gaps_on = !(request_count >= 150 && request_count < 190);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 99) < 8) send_line($urandom_range(LINE_LEN - 4, LINE_LEN + 2));
        else send_line($urandom_range(0, 12));
      end else if (pick < 85) begin
        send_pop(random_pop_len());
      end else if (pick < 90) begin
        send_request(ACT_UNUSED, 8'($urandom_range(0, 255)), random_pop_len());
      end else begin
        // broken line: some bytes, then a pop
        for (int i = $urandom_range(1, 4); i > 0; i--)
          send_request(ACT_PUSH, 8'($urandom_range(1, 255)), random_pop_len());
        send_pop(random_pop_len());
      end
    end
    start <= 1'b0;

    while (checker_h.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (checker_h.mismatch_count == 0 && checker_h.awaited_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
